// ===== rtl/humidity_temp_calib_convert_core_assert.svh =====
// Assertion macros shared by the calibration converter RTL.
`ifndef HUMIDITY_TEMP_CALIB_CONVERT_CORE_ASSERT_SVH
`define HUMIDITY_TEMP_CALIB_CONVERT_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define HCC_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define HCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HCC_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define HCC_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/hcc_pkg.sv =====
// Types and constants of the two-point calibration converter.
package hcc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW_PT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH_PT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_PT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_PT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW_CNT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH_CNT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW_CNT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH_CNT = 3'd7;

  localparam logic OP_HUM  = 1'b0;
  localparam logic OP_TEMP = 1'b1;

  localparam int CNT_W  = 16;
  localparam int HPT_W  = 8;
  localparam int TPT_W  = 10;
  localparam int SPAN_W = CNT_W + 1;
  localparam int PD_W   = TPT_W + 1;
  localparam int PROD_W = PD_W + SPAN_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int TEMP_SHIFT = 3;
  localparam int HUM_SHIFT  = 1;
  localparam int MAG_W  = PROD_W + TEMP_SHIFT;
  localparam int DIV_W  = CNT_W + HUM_SHIFT;
  localparam int QUOT_W = 17;
  localparam int WIDE_W = MAG_W + DIV_W;

  localparam logic [QUOT_W-1:0] TEMP_POS_LIMIT = 17'd32767;
  localparam logic [QUOT_W-1:0] TEMP_NEG_LIMIT = 17'd32768;
  localparam logic [QUOT_W-1:0] HUM_LIMIT      = 17'd100;

  localparam logic signed [CNT_W-1:0] TEMP_MAX_VAL = 16'sh7fff;
  localparam logic signed [CNT_W-1:0] TEMP_MIN_VAL = 16'sh8000;
  localparam logic signed [CNT_W-1:0] HUM_MAX_VAL  = 16'sd100;

  typedef struct packed {
    logic                    opcode;
    logic signed [CNT_W-1:0] raw_count;
  } sample_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] value;
    logic                    status;
  } result_t;

  typedef struct packed {
    logic [MAG_W-1:0]  rem;
    logic [QUOT_W-1:0] quot;
    logic [DIV_W-1:0]  divisor;
    logic              neg;
    logic              temp;
    logic              zero;
    logic              ovf;
  } div_stage_t;

endpackage

// ===== rtl/hcc_if.sv =====
// Request channels of the calibration converter: raw samples in, readings out.
interface hcc_sample_if import hcc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hcc_result_if import hcc_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/humidity_temp_calib_convert_core.sv =====
// Two-point linear calibration converter for humidity and temperature samples.
// A request passes through stages 0 to 2, the divider entry, the divider stages and the output register.
// One request is taken every cycle unless a stall backs up to the input; a full stage stalls when the next cannot load.
// The restoring divider, one quotient bit per stage over 17 stages, sets the depth.
// Synchronous reset clears all valid bits and the calibration registers to zero.
`include "humidity_temp_calib_convert_core_assert.svh"

module humidity_temp_calib_convert_core import hcc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  hcc_sample_if.sink           sample,
  hcc_result_if.source         result
);

  logic [HPT_W-1:0]        hum_low_pt;
  logic [HPT_W-1:0]        hum_high_pt;
  logic [TPT_W-1:0]        temp_low_pt;
  logic [TPT_W-1:0]        temp_high_pt;
  logic signed [CNT_W-1:0] hum_low_cnt;
  logic signed [CNT_W-1:0] hum_high_cnt;
  logic signed [CNT_W-1:0] temp_low_cnt;
  logic signed [CNT_W-1:0] temp_high_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      hum_low_pt    <= '0;
      hum_high_pt   <= '0;
      temp_low_pt   <= '0;
      temp_high_pt  <= '0;
      hum_low_cnt   <= '0;
      hum_high_cnt  <= '0;
      temp_low_cnt  <= '0;
      temp_high_cnt <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HUM_LOW_PT:    hum_low_pt    <= cfg_data[HPT_W-1:0];
        REG_HUM_HIGH_PT:   hum_high_pt   <= cfg_data[HPT_W-1:0];
        REG_TEMP_LOW_PT:   temp_low_pt   <= cfg_data[TPT_W-1:0];
        REG_TEMP_HIGH_PT:  temp_high_pt  <= cfg_data[TPT_W-1:0];
        REG_HUM_LOW_CNT:   hum_low_cnt   <= $signed(cfg_data[CNT_W-1:0]);
        REG_HUM_HIGH_CNT:  hum_high_cnt  <= $signed(cfg_data[CNT_W-1:0]);
        REG_TEMP_LOW_CNT:  temp_low_cnt  <= $signed(cfg_data[CNT_W-1:0]);
        REG_TEMP_HIGH_CNT: temp_high_cnt <= $signed(cfg_data[CNT_W-1:0]);
        default: ;
      endcase
    end
  end

  // Stall chain: a stage may load when it is empty or its contents move on.
  logic                s0_vld;
  logic                s1_vld;
  logic                s2_vld;
  logic [QUOT_W:0]     dv_vld;
  logic                out_vld;
  logic                en_s0;
  logic                en_s1;
  logic                en_s2;
  logic [QUOT_W:0]     en_dv;
  logic                en_out;

  assign en_out = !out_vld || result.ready;
  assign en_dv[QUOT_W] = !dv_vld[QUOT_W] || en_out;

  genvar g;
  generate
    for (g = 0; g < QUOT_W; g++) begin : g_en
      assign en_dv[g] = !dv_vld[g] || en_dv[g+1];
    end
  endgenerate

  assign en_s2 = !s2_vld || en_dv[0];
  assign en_s1 = !s1_vld || en_s2;
  assign en_s0 = !s0_vld || en_s1;
  assign sample.ready = !rst && en_s0;

  // Stage 0: pick the calibration set and form the differences.
  logic [TPT_W-1:0]         sel_lo_pt;
  logic [TPT_W-1:0]         sel_hi_pt;
  logic signed [CNT_W-1:0]  sel_lo_cnt;
  logic signed [CNT_W-1:0]  sel_hi_cnt;
  logic signed [SPAN_W-1:0] sel_span;
  logic signed [SPAN_W-1:0] sel_diff;
  logic signed [PD_W-1:0]   sel_pd;

  always_comb begin
    if (sample.payload.opcode == OP_TEMP) begin
      sel_lo_pt  = temp_low_pt;
      sel_hi_pt  = temp_high_pt;
      sel_lo_cnt = temp_low_cnt;
      sel_hi_cnt = temp_high_cnt;
    end else begin
      sel_lo_pt  = TPT_W'(hum_low_pt);
      sel_hi_pt  = TPT_W'(hum_high_pt);
      sel_lo_cnt = hum_low_cnt;
      sel_hi_cnt = hum_high_cnt;
    end
    sel_span = SPAN_W'(sel_hi_cnt) - SPAN_W'(sel_lo_cnt);
    sel_diff = SPAN_W'($signed(sample.payload.raw_count)) - SPAN_W'(sel_lo_cnt);
    sel_pd   = $signed({1'b0, sel_hi_pt}) - $signed({1'b0, sel_lo_pt});
  end

  logic                     s0_temp;
  logic signed [SPAN_W-1:0] s0_span;
  logic signed [SPAN_W-1:0] s0_diff;
  logic signed [PD_W-1:0]   s0_pdelta;
  logic [TPT_W-1:0]         s0_lopt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en_s0) begin
      s0_vld <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s0 && sample.valid) begin
      s0_temp   <= (sample.payload.opcode == OP_TEMP);
      s0_span   <= sel_span;
      s0_diff   <= sel_diff;
      s0_pdelta <= sel_pd;
      s0_lopt   <= sel_lo_pt;
    end
  end

  // Stage 1: the two products of the numerator and the span magnitude.
  logic signed [SPAN_W-1:0] s0_span_abs;
  assign s0_span_abs = s0_span[SPAN_W-1] ? -s0_span : s0_span;

  logic                     s1_temp;
  logic                     s1_zero;
  logic                     s1_span_neg;
  logic [CNT_W-1:0]         s1_span_mag;
  logic signed [PROD_W-1:0] s1_p0;
  logic signed [PROD_W-1:0] s1_p1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en_s1) begin
      s1_vld <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1 && s0_vld) begin
      s1_temp     <= s0_temp;
      s1_zero     <= (s0_span == '0);
      s1_span_neg <= s0_span[SPAN_W-1];
      s1_span_mag <= s0_span_abs[CNT_W-1:0];
      s1_p0       <= $signed({1'b0, s0_lopt}) * s0_span;
      s1_p1       <= s0_diff * s0_pdelta;
    end
  end

  // Stage 2: numerator, sign of the quotient and scaled magnitudes.
  logic signed [NUM_W-1:0] s1_num;
  logic signed [NUM_W-1:0] s1_num_abs;
  assign s1_num     = NUM_W'(s1_p0) + NUM_W'(s1_p1);
  assign s1_num_abs = s1_num[NUM_W-1] ? -s1_num : s1_num;

  logic              s2_temp;
  logic              s2_zero;
  logic              s2_neg;
  logic [MAG_W-1:0]  s2_mag;
  logic [DIV_W-1:0]  s2_div;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en_s2) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_s2 && s1_vld) begin
      s2_temp <= s1_temp;
      s2_zero <= s1_zero;
      s2_neg  <= s1_num[NUM_W-1] ^ s1_span_neg;
      if (s1_temp) begin
        s2_mag <= MAG_W'(s1_num_abs[PROD_W-1:0]) << TEMP_SHIFT;
        s2_div <= DIV_W'(s1_span_mag);
      end else begin
        s2_mag <= MAG_W'(s1_num_abs[PROD_W-1:0]);
        s2_div <= DIV_W'(s1_span_mag) << HUM_SHIFT;
      end
    end
  end

  // Divider entry: flag quotients too large for the quotient width.
  div_stage_t dv [0:QUOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (en_dv[0]) begin
      dv_vld[0] <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en_dv[0] && s2_vld) begin
      dv[0].rem     <= s2_mag;
      dv[0].quot    <= '0;
      dv[0].divisor <= s2_div;
      dv[0].neg     <= s2_neg;
      dv[0].temp    <= s2_temp;
      dv[0].zero    <= s2_zero;
      dv[0].ovf     <= (WIDE_W'(s2_mag) >= (WIDE_W'(s2_div) << QUOT_W));
    end
  end

  // Restoring division, one quotient bit per stage, most significant first.
  generate
    for (g = 0; g < QUOT_W; g++) begin : g_div
      localparam int BIT = QUOT_W - 1 - g;
      logic [WIDE_W-1:0] trial;
      logic              fits;
      div_stage_t        step;

      assign trial = WIDE_W'(dv[g].divisor) << BIT;
      assign fits  = (WIDE_W'(dv[g].rem) >= trial);

      always_comb begin
        step           = dv[g];
        step.rem       = fits ? (dv[g].rem - trial[MAG_W-1:0]) : dv[g].rem;
        step.quot[BIT] = fits;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          dv_vld[g+1] <= 1'b0;
        end else if (en_dv[g+1]) begin
          dv_vld[g+1] <= dv_vld[g];
        end
      end

      always_ff @(posedge clk) begin
        if (en_dv[g+1] && dv_vld[g]) begin
          dv[g+1] <= step;
        end
      end
    end
  endgenerate

  // Output stage: sign, clamp or saturate, zero-span flag.
  div_stage_t last;
  result_t    res_next;
  result_t    out_data;

  assign last = dv[QUOT_W];

  always_comb begin
    res_next.status = 1'b0;
    if (last.zero) begin
      res_next.value  = '0;
      res_next.status = 1'b1;
    end else if (last.temp) begin
      if (last.neg) begin
        if (last.ovf || last.quot > TEMP_NEG_LIMIT) begin
          res_next.value = TEMP_MIN_VAL;
        end else begin
          res_next.value = CNT_W'(0) - last.quot[CNT_W-1:0];
        end
      end else begin
        if (last.ovf || last.quot > TEMP_POS_LIMIT) begin
          res_next.value = TEMP_MAX_VAL;
        end else begin
          res_next.value = last.quot[CNT_W-1:0];
        end
      end
    end else begin
      if (last.neg) begin
        res_next.value = '0;
      end else if (last.ovf || last.quot > HUM_LIMIT) begin
        res_next.value = HUM_MAX_VAL;
      end else begin
        res_next.value = last.quot[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en_out) begin
      out_vld <= dv_vld[QUOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && dv_vld[QUOT_W]) begin
      out_data <= res_next;
    end
  end

  assign result.valid   = out_vld;
  assign result.payload = out_data;

  `HCC_ASSERT_NEXT(a_request_enters, clk, rst, sample.valid && sample.ready, s0_vld)
  `HCC_ASSERT_IMPL(a_rem_below_div, clk, rst, dv_vld[QUOT_W] && !last.zero && !last.ovf, last.rem < MAG_W'(last.divisor))
  `HCC_ASSERT_IMPL(a_zero_span_value, clk, rst, result.valid && result.payload.status, result.payload.value == '0)

endmodule

// ===== dv/tb_humidity_temp_calib_convert_core.sv =====
// Self-checking testbench for the two-point humidity and temperature calibration converter.
module tb_humidity_temp_calib_convert_core;
  import hcc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  class reading_tracker;
    logic [HPT_W-1:0]        hum_lo_pt, hum_hi_pt;
    logic [TPT_W-1:0]        temp_lo_pt, temp_hi_pt;
    logic signed [CNT_W-1:0] hum_lo_cnt, hum_hi_cnt, temp_lo_cnt, temp_hi_cnt;
    result_t                 readings_due[$];
    int                      errors;
    int                      readings_checked;

    function new();
      hum_lo_pt = '0;
      hum_hi_pt = '0;
      temp_lo_pt = '0;
      temp_hi_pt = '0;
      hum_lo_cnt = '0;
      hum_hi_cnt = '0;
      temp_lo_cnt = '0;
      temp_hi_cnt = '0;
      errors = 0;
      readings_checked = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_HUM_LOW_PT:    hum_lo_pt = data[HPT_W-1:0];
        REG_HUM_HIGH_PT:   hum_hi_pt = data[HPT_W-1:0];
        REG_TEMP_LOW_PT:   temp_lo_pt = data[TPT_W-1:0];
        REG_TEMP_HIGH_PT:  temp_hi_pt = data[TPT_W-1:0];
        REG_HUM_LOW_CNT:   hum_lo_cnt = data;
        REG_HUM_HIGH_CNT:  hum_hi_cnt = data;
        REG_TEMP_LOW_CNT:  temp_lo_cnt = data;
        REG_TEMP_HIGH_CNT: temp_hi_cnt = data;
        default: ;
      endcase
    endfunction

    function result_t calibrate(sample_t s);
      longint  raw, lo_pt, hi_pt, lo_cnt, hi_cnt, span, num, v;
      result_t r;
      raw = longint'(signed'(s.raw_count));
      if (s.opcode == OP_TEMP) begin
        lo_pt = temp_lo_pt;
        hi_pt = temp_hi_pt;
        lo_cnt = temp_lo_cnt;
        hi_cnt = temp_hi_cnt;
      end else begin
        lo_pt = hum_lo_pt;
        hi_pt = hum_hi_pt;
        lo_cnt = hum_lo_cnt;
        hi_cnt = hum_hi_cnt;
      end
      span = hi_cnt - lo_cnt;
      v = 0;
      r.status = (span == 0);
      if (span != 0) begin
        num = lo_pt * span + (raw - lo_cnt) * (hi_pt - lo_pt);
        if (s.opcode == OP_TEMP) begin
          v = (8 * num) / span;
          if (v > 32767) v = 32767;
          else if (v < -32768) v = -32768;
        end else begin
          v = num / (2 * span);
          if (v > 100) v = 100;
          else if (v < 0) v = 0;
        end
      end
      r.value = v[CNT_W-1:0];
      return r;
    endfunction

    function void note_sample(sample_t s);
      readings_due.push_back(calibrate(s));
    endfunction

    function void check_reading(result_t got);
      result_t want;
      readings_checked++;
      if (readings_due.size() == 0) begin
        errors++;
        $display("%0t: reading with none expected: expected nothing, got value %0d status %0b",
                 $time, got.value, got.status);
        return;
      end
      want = readings_due.pop_front();
      if (got.value !== want.value) begin
        errors++;
        $display("%0t: value mismatch: expected %0d, got %0d", $time, want.value, got.value);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0b, got %0b", $time, want.status, got.status);
      end
    endfunction

    function int pending();
      return readings_due.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 calm = 1'b0;
  int                   cycles = 0;
  logic [CNT_W-1:0]     cal_shadow [8];
  reading_tracker       board = new();

  hcc_sample_if sample_ch ();
  hcc_result_if result_ch ();

  humidity_temp_calib_convert_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && sample_ch.valid && sample_ch.ready) board.note_sample(sample_ch.payload);
    if (!rst && result_ch.valid && result_ch.ready) board.check_reading(result_ch.payload);
  end

  // The receiver stalls once for a long stretch so that the pipeline fills and backs up.
  initial begin
    int   held;
    logic pressed;
    held = 0;
    pressed = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!pressed && board.readings_checked >= 300) begin
        pressed = 1'b1;
        held = 120;
      end
      if (held > 0) begin
        result_ch.ready = 1'b0;
        held--;
      end else begin
        result_ch.ready = calm || ($urandom_range(99) >= 28);
      end
    end
  end

  task automatic send_sample(logic op, logic [CNT_W-1:0] raw);
    while (!calm && $urandom_range(99) < 28) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.payload.opcode = op;
    sample_ch.payload.raw_count = raw;
    sample_ch.valid = 1'b1;
    do @(posedge clk); while (!sample_ch.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    sample_ch.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    board.write_reg(idx, data);
    cal_shadow[idx] = data;
  endtask

  // Unused upper data bits of the point registers carry noise; the block must drop them.
  task automatic write_calibration(int hlp, int hhp, int tlp, int thp,
                                   logic [CNT_W-1:0] hlc, logic [CNT_W-1:0] hhc,
                                   logic [CNT_W-1:0] tlc, logic [CNT_W-1:0] thc);
    write_reg(REG_HUM_LOW_PT, {8'($urandom_range(255)), 8'(hlp)});
    write_reg(REG_HUM_HIGH_PT, {8'($urandom_range(255)), 8'(hhp)});
    write_reg(REG_TEMP_LOW_PT, {6'($urandom_range(63)), 10'(tlp)});
    write_reg(REG_TEMP_HIGH_PT, {6'($urandom_range(63)), 10'(thp)});
    write_reg(REG_HUM_LOW_CNT, hlc);
    write_reg(REG_HUM_HIGH_CNT, hhc);
    write_reg(REG_TEMP_LOW_CNT, tlc);
    write_reg(REG_TEMP_HIGH_CNT, thc);
  endtask

  function automatic int pick_point(int top);
    int r;
    r = $urandom_range(9);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(top);
  endfunction

  function automatic logic [CNT_W-1:0] pick_high_count(logic [CNT_W-1:0] lo);
    int kind;
    int delta;
    kind = $urandom_range(19);
    if (kind == 0) return lo;
    if (kind > 12) return 16'($urandom);
    if (kind <= 5) delta = $urandom_range(16, 1);
    else delta = $urandom_range(3000, 50);
    if ($urandom_range(1) == 1) delta = -delta;
    return lo + 16'(delta);
  endfunction

  function automatic logic [CNT_W-1:0] gen_raw(logic [CNT_W-1:0] lo, logic [CNT_W-1:0] hi);
    int a, b, m, off, pos;
    if ($urandom_range(9) < 4) return 16'($urandom);
    a = int'(signed'(lo));
    b = int'(signed'(hi));
    m = ((b > a) ? b - a : a - b) / 4 + 8;
    off = int'($urandom_range(2 * m)) - m;
    pos = a + (int'($urandom_range(1000)) * (b - a)) / 1000 + off;
    return 16'(pos);
  endfunction

  initial begin
    logic             op;
    logic [CNT_W-1:0] raw, hlc, tlc;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.payload = '0;
    for (int k = 0; k < 8; k++) cal_shadow[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // After reset every span is zero.
    send_sample(OP_HUM, 16'h0000);
    send_sample(OP_TEMP, 16'hffff);

    settle();
    write_calibration(0, 200, 0, 1023, -16'sd1000, 16'sd1000, 16'sd0, 16'sd1);
    send_sample(OP_HUM, 16'h8000);
    send_sample(OP_HUM, 16'h7fff);
    send_sample(OP_HUM, 16'h0000);
    send_sample(OP_HUM, -16'sd1000);
    send_sample(OP_HUM, 16'sd999);
    send_sample(OP_TEMP, 16'h7fff);
    send_sample(OP_TEMP, 16'h8000);
    send_sample(OP_TEMP, 16'h0000);
    send_sample(OP_TEMP, 16'h0001);

    settle();
    write_calibration(255, 0, 1023, 0, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    send_sample(OP_HUM, 16'h7fff);
    send_sample(OP_HUM, 16'h8000);
    send_sample(OP_TEMP, 16'h7fff);
    send_sample(OP_TEMP, 16'h8000);
    send_sample(OP_TEMP, 16'h0000);

    settle();
    write_calibration(10, 90, 1023, 1023, 16'sd123, 16'sd123, -16'sd5, 16'sd5);
    send_sample(OP_HUM, 16'h8000);
    send_sample(OP_TEMP, 16'h8000);
    send_sample(OP_TEMP, 16'h7fff);

    for (int p = 0; p < 10; p++) begin
      settle();
      calm = (p == 6);
      hlc = 16'($urandom);
      tlc = 16'($urandom);
      write_calibration(pick_point(255), pick_point(255), pick_point(1023), pick_point(1023),
                        hlc, pick_high_count(hlc), tlc, pick_high_count(tlc));
      for (int i = 0; i < 85; i++) begin
        op = 1'($urandom_range(1));
        if (op == OP_HUM) raw = gen_raw(cal_shadow[REG_HUM_LOW_CNT], cal_shadow[REG_HUM_HIGH_CNT]);
        else raw = gen_raw(cal_shadow[REG_TEMP_LOW_CNT], cal_shadow[REG_TEMP_HIGH_CNT]);
        send_sample(op, raw);
      end
    end

    calm = 1'b0;
    settle();
    repeat (30) @(negedge clk);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/hcc_pkg.sv
rtl/hcc_if.sv
rtl/humidity_temp_calib_convert_core.sv
dv/tb_humidity_temp_calib_convert_core.sv
